// ===== rtl/core/vsq_pkg.sv =====
// shared types and constants for the voxel surface query unit
// holds the controller state enum, the command and status structs and register codes
// no dependencies
package vsq_pkg;

    localparam int GRID_DIM_DEFAULT      = 32;
    localparam int MATERIAL_BITS_DEFAULT = 8;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_DEPTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z    = 3'd5;

    // item modes
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // read sequence: center voxel, then the six neighbors
    typedef logic [2:0] t_step;
    localparam t_step STEP_CENTER  = 3'd0;
    localparam t_step STEP_X_MINUS = 3'd1;
    localparam t_step STEP_X_PLUS  = 3'd2;
    localparam t_step STEP_Y_MINUS = 3'd3;
    localparam t_step STEP_Y_PLUS  = 3'd4;
    localparam t_step STEP_Z_MINUS = 3'd5;
    localparam t_step STEP_Z_PLUS  = 3'd6;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_START,
        ST_READ,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic  load;
        logic  clr_en;
        logic  wr_en;
        logic  rd_en;
        t_step step;
        logic  out_load;
    } t_ctrl_cmd;

    typedef struct packed {
        logic clr_last;
        logic err;
        logic is_query;
        logic out_free;
    } t_ctrl_status;

endpackage

// ===== rtl/core/vsq_ctrl.sv =====
// sequencer for the voxel surface query unit
// drives the datapath by command struct, depends on vsq_pkg
module vsq_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  vsq_pkg::t_ctrl_status i_status,
    output vsq_pkg::t_ctrl_cmd    o_cmd
);
    import vsq_pkg::*;

    t_state r_state, n_state;
    t_step  r_step, n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_step  <= STEP_CENTER;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_en = 1'b1;
                if (i_status.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_START;
                end
            end
            ST_START: begin
                if (!i_status.err && i_status.is_query) begin
                    o_cmd.rd_en = 1'b1;
                    o_cmd.step  = STEP_CENTER;
                    n_step      = STEP_X_MINUS;
                    n_state     = ST_READ;
                end else begin
                    o_cmd.wr_en = !i_status.err;
                    n_state     = ST_FINISH;
                end
            end
            ST_READ: begin
                o_cmd.rd_en = 1'b1;
                o_cmd.step  = r_step;
                if (r_step == STEP_Z_PLUS) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_step = r_step + 3'd1;
                end
            end
            ST_DRAIN: begin
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_load_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_status.out_free)
        else $error("result loaded while output register still full");
    a_write_is_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.wr_en |-> (!i_status.is_query && !i_status.err))
        else $error("store written by a query or out of range item");
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == ST_START))
        else $error("accepted item did not start");
`endif

endmodule

// ===== rtl/core/vsq_datapath.sv =====
// datapath of the voxel surface query unit: config registers, voxel memory,
// item registers, neighbor evaluation and output register; depends on vsq_pkg
module vsq_datapath #(
    parameter int GRID_DIM      = vsq_pkg::GRID_DIM_DEFAULT,
    parameter int MATERIAL_BITS = vsq_pkg::MATERIAL_BITS_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [vsq_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [vsq_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    input  logic                                i_mode,
    input  logic [4:0]                          i_pos_x,
    input  logic [4:0]                          i_pos_y,
    input  logic [4:0]                          i_pos_z,
    input  logic [7:0]                          i_material_in,
    input  vsq_pkg::t_ctrl_cmd                  i_cmd,
    output vsq_pkg::t_ctrl_status               o_status,
    input  logic                                i_ready,
    output logic                                o_valid,
    output logic                                o_visible,
    output logic signed [15:0]                  o_world_x,
    output logic signed [15:0]                  o_world_y,
    output logic signed [15:0]                  o_world_z,
    output logic [7:0]                          o_material_out,
    output logic                                o_coord_error
);
    import vsq_pkg::*;

    localparam int CW    = $clog2(GRID_DIM);
    localparam int PW    = (CW > 5) ? CW : 5;
    localparam int AW    = 3 * CW;
    localparam int DEPTH = 1 << AW;
    localparam int MB    = MATERIAL_BITS;
    localparam int MW    = (MB > 8) ? MB : 8;
    localparam int EXW   = ($clog2(GRID_DIM + 1) > 6) ? $clog2(GRID_DIM + 1) : 6;
    localparam logic [EXW-1:0] G_EXT = EXW'(GRID_DIM);

    // configuration
    logic [5:0]  r_grid_width, r_grid_height, r_grid_depth;
    logic [14:0] r_origin_x, r_origin_y, r_origin_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= 6'd32;
            r_grid_height <= 6'd32;
            r_grid_depth  <= 6'd32;
            r_origin_x    <= '0;
            r_origin_y    <= '0;
            r_origin_z    <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_GRID_WIDTH:  r_grid_width  <= i_cfg_wdata[5:0];
                CFG_GRID_HEIGHT: r_grid_height <= i_cfg_wdata[5:0];
                CFG_GRID_DEPTH:  r_grid_depth  <= i_cfg_wdata[5:0];
                CFG_ORIGIN_X:    r_origin_x    <= i_cfg_wdata;
                CFG_ORIGIN_Y:    r_origin_y    <= i_cfg_wdata;
                CFG_ORIGIN_Z:    r_origin_z    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // item registers
    logic          r_mode;
    logic [4:0]    r_x, r_y, r_z;
    logic [MB-1:0] r_mat_in;
    logic [MW-1:0] mat_in_ext;

    assign mat_in_ext = MW'(i_material_in);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode   <= i_mode;
            r_x      <= i_pos_x;
            r_y      <= i_pos_y;
            r_z      <= i_pos_z;
            r_mat_in <= mat_in_ext[MB-1:0];
        end
    end

    // extents saturate at the grid size
    logic [EXW-1:0] w_use, h_use, d_use;
    logic [EXW-1:0] x_ext, y_ext, z_ext;
    logic           err, boundary;

    assign w_use = (EXW'(r_grid_width)  > G_EXT) ? G_EXT : EXW'(r_grid_width);
    assign h_use = (EXW'(r_grid_height) > G_EXT) ? G_EXT : EXW'(r_grid_height);
    assign d_use = (EXW'(r_grid_depth)  > G_EXT) ? G_EXT : EXW'(r_grid_depth);
    assign x_ext = EXW'(r_x);
    assign y_ext = EXW'(r_y);
    assign z_ext = EXW'(r_z);

    assign err = !((x_ext < w_use) && (y_ext < h_use) && (z_ext < d_use));
    assign boundary = (r_x == 5'd0) || (r_y == 5'd0) || (r_z == 5'd0) ||
                      ((x_ext + EXW'(1)) == w_use) ||
                      ((y_ext + EXW'(1)) == h_use) ||
                      ((z_ext + EXW'(1)) == d_use);

    // memory coordinates
    logic [PW-1:0] px, py, pz;
    logic [CW-1:0] cx, cy, cz;
    logic [CW-1:0] nx, ny, nz;
    logic [AW-1:0] item_addr, rd_addr;

    assign px = PW'(r_x);
    assign py = PW'(r_y);
    assign pz = PW'(r_z);
    assign cx = px[CW-1:0];
    assign cy = py[CW-1:0];
    assign cz = pz[CW-1:0];
    assign item_addr = {cz, cy, cx};

    always_comb begin
        nx = cx;
        ny = cy;
        nz = cz;
        unique case (i_cmd.step)
            STEP_CENTER:  ;
            STEP_X_MINUS: nx = cx - CW'(1);
            STEP_X_PLUS:  nx = cx + CW'(1);
            STEP_Y_MINUS: ny = cy - CW'(1);
            STEP_Y_PLUS:  ny = cy + CW'(1);
            STEP_Z_MINUS: nz = cz - CW'(1);
            STEP_Z_PLUS:  nz = cz + CW'(1);
            default: ;
        endcase
    end

    assign rd_addr = {nz, ny, nx};

    // voxel memory and clearing counter
    logic [MB-1:0] r_mem [0:DEPTH-1];
    logic [MB-1:0] r_rd_data;
    logic [AW-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_en) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_en) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_cmd.wr_en) begin
            r_mem[item_addr] <= r_mat_in;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // neighbor evaluation, in the cycle after the read
    logic          r_rd_vld;
    t_step         r_rd_step;
    logic [MB-1:0] r_center;
    logic          r_any_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_step <= i_cmd.step;
        end
        if (i_cmd.load) begin
            r_any_empty <= 1'b0;
        end else if (r_rd_vld) begin
            if (r_rd_step == STEP_CENTER) begin
                r_center <= r_rd_data;
            end else if (r_rd_data == '0) begin
                r_any_empty <= 1'b1;
            end
        end
    end

    // result
    logic          is_query;
    logic [MB-1:0] mat_sel;
    logic [MW-1:0] mat_sel_ext;
    logic          vis;

    assign is_query    = (r_mode == MODE_QUERY);
    assign mat_sel     = err ? '0 : (is_query ? r_center : r_mat_in);
    assign mat_sel_ext = MW'(mat_sel);
    assign vis         = !err && is_query && (r_center != '0) && (boundary || r_any_empty);

    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_visible      <= vis;
            o_world_x      <= {r_origin_x[14], r_origin_x} + {11'd0, r_x};
            o_world_y      <= {r_origin_y[14], r_origin_y} + {11'd0, r_y};
            o_world_z      <= {r_origin_z[14], r_origin_z} + {11'd0, r_z};
            o_material_out <= mat_sel_ext[7:0];
            o_coord_error  <= err;
        end
    end

    assign o_valid = r_out_valid;

    assign o_status.clr_last = &r_clr_addr;
    assign o_status.err      = err;
    assign o_status.is_query = is_query;
    assign o_status.out_free = !r_out_valid || i_ready;

`ifndef NO_ASSERTIONS
    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> o_valid)
        else $error("loaded result not presented");
    a_visible_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_visible) |-> !o_coord_error)
        else $error("out of range item reported visible");
    a_no_access_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clr_en |-> (!i_cmd.wr_en && !i_cmd.rd_en && !i_cmd.load))
        else $error("memory accessed during clearing pass");
`endif

endmodule

// ===== rtl/core/voxel_surface_query_unit.sv =====
// top level of the voxel surface query unit
// instantiates vsq_ctrl and vsq_datapath, depends on vsq_pkg
//
// usage
//   input channel (i_valid / o_ready) carries one item: mode, local position and
//   material; mode write stores the material, mode query tests visibility
//   output channel (o_valid / i_ready) returns one result per item: visible flag,
//   world position, material at the voxel and the coordinate error flag
//   config port: i_cfg_wr_en with i_cfg_index and i_cfg_wdata writes one register
//   per cycle; the user writes only while no item is in flight, which is unchecked
// sequence
//   a query reads the center voxel, then the six neighbors, from the voxel memory
//   one per cycle, then passes a drain step and registers its result in finish
//   a write stores in the start step; it and an out of range item skip the reads
//   the next item is taken once the result is in the output register
// reset
//   synchronous active-low reset restores the config registers, then a clearing
//   pass zeroes the voxel memory, one entry per cycle, 2^(3*clog2(GRID_DIM))
//   entries (32768 at the default size); o_ready stays low until it ends
// stall
//   the result waits in the output register while i_ready is low; the next item
//   is still taken and worked on, and holds in its final step until the
//   register frees up
module voxel_surface_query_unit #(
    parameter int GRID_DIM      = vsq_pkg::GRID_DIM_DEFAULT,
    parameter int MATERIAL_BITS = vsq_pkg::MATERIAL_BITS_DEFAULT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration
    input  logic                           i_cfg_wr_en,
    input  logic [vsq_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [vsq_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    // input items
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_mode,
    input  logic [4:0]                     i_pos_x,
    input  logic [4:0]                     i_pos_y,
    input  logic [4:0]                     i_pos_z,
    input  logic [7:0]                     i_material_in,
    // results
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic                           o_visible,
    output logic signed [15:0]             o_world_x,
    output logic signed [15:0]             o_world_y,
    output logic signed [15:0]             o_world_z,
    output logic [7:0]                     o_material_out,
    output logic                           o_coord_error
);
    import vsq_pkg::*;

    // command and status between sequencer and datapath
    t_ctrl_cmd    cmd;
    t_ctrl_status status;

    vsq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    vsq_datapath #(
        .GRID_DIM      (GRID_DIM),
        .MATERIAL_BITS (MATERIAL_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_mode         (i_mode),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_pos_z        (i_pos_z),
        .i_material_in  (i_material_in),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_ready        (i_ready),
        .o_valid        (o_valid),
        .o_visible      (o_visible),
        .o_world_x      (o_world_x),
        .o_world_y      (o_world_y),
        .o_world_z      (o_world_z),
        .o_material_out (o_material_out),
        .o_coord_error  (o_coord_error)
    );

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// self-checking bench for voxel_surface_query_unit: directed surface, extent and origin
// cases, then random write/query traffic against an in-bench voxel grid predictor
// depends on vsq_pkg and the unit's rtl
module testbench;
    import vsq_pkg::*;

    localparam int CLK_HALF    = 6;
    localparam int GRID        = 32;
    // the clearing pass after reset zeroes 32768 entries, so the limit sits well above it
    localparam int STALL_LIMIT = 150000;
    localparam int MAX_PRINTS  = 30;
    localparam int SETTLE      = 12;

    typedef struct {
        logic               visible;
        logic signed [15:0] world_x;
        logic signed [15:0] world_y;
        logic signed [15:0] world_z;
        logic [7:0]         material;
        logic               coord_error;
    } t_voxel_result;

    // clock, reset and dut inputs, all known from time zero
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = CFG_GRID_WIDTH;
    logic [CFG_DATA_W-1:0] i_cfg_wdata   = '0;
    logic                  i_valid       = 1'b0;
    logic                  o_ready;
    logic                  i_mode        = MODE_WRITE;
    logic [4:0]            i_pos_x       = '0;
    logic [4:0]            i_pos_y       = '0;
    logic [4:0]            i_pos_z       = '0;
    logic [7:0]            i_material_in = '0;
    logic                  o_valid;
    logic                  i_ready       = 1'b0;
    logic                  o_visible;
    logic signed [15:0]    o_world_x;
    logic signed [15:0]    o_world_y;
    logic signed [15:0]    o_world_z;
    logic [7:0]            o_material_out;
    logic                  o_coord_error;

    // predictor state: voxel grid and register copies at their reset values
    bit [7:0]  voxel_grid [0:GRID*GRID*GRID-1];
    bit [5:0]  ext_w = 6'd32;
    bit [5:0]  ext_h = 6'd32;
    bit [5:0]  ext_d = 6'd32;
    bit [14:0] org_x = '0;
    bit [14:0] org_y = '0;
    bit [14:0] org_z = '0;

    t_voxel_result pending_results [$];

    int send_idle_pct = 17;
    int recv_idle_pct = 69;
    int mismatches    = 0;
    int items_sent    = 0;
    int results_seen  = 0;
    int n_writes      = 0;
    int n_queries     = 0;
    int n_range_err   = 0;
    int n_visible     = 0;
    int n_enclosed    = 0;
    int n_cfg_writes  = 0;
    int idle_cycles   = 0;

    voxel_surface_query_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_mode         (i_mode),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_pos_z        (i_pos_z),
        .i_material_in  (i_material_in),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_visible      (o_visible),
        .o_world_x      (o_world_x),
        .o_world_y      (o_world_y),
        .o_world_z      (o_world_z),
        .o_material_out (o_material_out),
        .o_coord_error  (o_coord_error)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // grid entry address: x fastest, then y, then z
    function automatic bit [14:0] cell_addr(logic [4:0] x, logic [4:0] y, logic [4:0] z);
        return {z, y, x};
    endfunction

    // register values above the grid size saturate
    function automatic int clamp_extent(bit [5:0] ext);
        return (ext > GRID) ? GRID : int'(ext);
    endfunction

    // sign-extended 15-bit origin plus the local coordinate, kept to 16 bits
    function automatic logic signed [15:0] to_world(bit [14:0] org, logic [4:0] loc);
        return {org[14], org} + {11'd0, loc};
    endfunction

    function automatic t_voxel_result predict_voxel(logic mode, logic [4:0] x, logic [4:0] y,
                                                    logic [4:0] z, logic [7:0] mat);
        t_voxel_result r;
        int            w;
        int            h;
        int            d;
        bit [7:0]      center;
        w = clamp_extent(ext_w);
        h = clamp_extent(ext_h);
        d = clamp_extent(ext_d);
        r.visible     = 1'b0;
        r.material    = '0;
        r.coord_error = !(x < w && y < h && z < d);
        r.world_x     = to_world(org_x, x);
        r.world_y     = to_world(org_y, y);
        r.world_z     = to_world(org_z, z);
        if (r.coord_error) begin
            // out of range: writes dropped, queries report nothing
            n_range_err++;
        end else if (mode == MODE_WRITE) begin
            voxel_grid[cell_addr(x, y, z)] = mat;
            r.material = mat;
            n_writes++;
        end else begin
            center     = voxel_grid[cell_addr(x, y, z)];
            r.material = center;
            n_queries++;
            if (center != 0) begin
                // boundary of the extent in use wins before any neighbor is looked at
                if (x == 0 || y == 0 || z == 0 || x == w - 1 || y == h - 1 || z == d - 1) begin
                    r.visible = 1'b1;
                end else if (voxel_grid[cell_addr(x - 5'd1, y, z)] == 0 ||
                             voxel_grid[cell_addr(x + 5'd1, y, z)] == 0 ||
                             voxel_grid[cell_addr(x, y - 5'd1, z)] == 0 ||
                             voxel_grid[cell_addr(x, y + 5'd1, z)] == 0 ||
                             voxel_grid[cell_addr(x, y, z - 5'd1)] == 0 ||
                             voxel_grid[cell_addr(x, y, z + 5'd1)] == 0) begin
                    r.visible = 1'b1;
                end
                if (r.visible) n_visible++;
                else n_enclosed++;
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // mismatch reporting and result checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(string what, int want, int got);
        mismatches++;
        if (mismatches <= MAX_PRINTS) begin
            $display("mismatch on result %0d, %s: expected %0d, got %0d at %0t",
                     results_seen, what, want, got, $realtime);
        end
    endtask

    // compares each output transfer with the oldest pending prediction
    always @(posedge i_clk) begin
        t_voxel_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending", 0, 1);
            end else begin
                want = pending_results.pop_front();
                if (o_visible !== want.visible)
                    report_mismatch("visible", want.visible, o_visible);
                if (o_world_x !== want.world_x)
                    report_mismatch("world_x", want.world_x, o_world_x);
                if (o_world_y !== want.world_y)
                    report_mismatch("world_y", want.world_y, o_world_y);
                if (o_world_z !== want.world_z)
                    report_mismatch("world_z", want.world_z, o_world_z);
                if (o_material_out !== want.material)
                    report_mismatch("material_out", want.material, o_material_out);
                if (o_coord_error !== want.coord_error)
                    report_mismatch("coord_error", want.coord_error, o_coord_error);
            end
            results_seen++;
        end
    end

    // result side stalls at random, new decision each cycle
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog: cycles in a row with no transfer on either channel
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no transfer for %0d cycles, %0d results still pending",
                     STALL_LIMIT, pending_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // one input transfer; the prediction is made at the accepting edge
    task automatic send_item(logic mode, logic [4:0] x, logic [4:0] y, logic [4:0] z,
                             logic [7:0] mat);
        t_voxel_result pred;
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid       <= 1'b1;
        i_mode        <= mode;
        i_pos_x       <= x;
        i_pos_y       <= y;
        i_pos_z       <= z;
        i_material_in <= mat;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pred            = predict_voxel(mode, x, y, z, mat);
        pending_results = {pending_results, pred};
        items_sent++;
    endtask

    task automatic write_vox(logic [4:0] x, logic [4:0] y, logic [4:0] z, logic [7:0] mat);
        send_item(MODE_WRITE, x, y, z, mat);
    endtask

    task automatic query_vox(logic [4:0] x, logic [4:0] y, logic [4:0] z);
        // material field is don't-care on a query, so keep it moving
        send_item(MODE_QUERY, x, y, z, 8'($urandom()));
    endtask

    // stop sending, let every pending result come back, then let the pipe settle
    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        case (idx)
            CFG_GRID_WIDTH:  ext_w = data[5:0];
            CFG_GRID_HEIGHT: ext_h = data[5:0];
            CFG_GRID_DEPTH:  ext_d = data[5:0];
            CFG_ORIGIN_X:    org_x = data;
            CFG_ORIGIN_Y:    org_y = data;
            CFG_ORIGIN_Z:    org_z = data;
            default: ;
        endcase
        n_cfg_writes++;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // all six registers; only called with nothing in flight
    task automatic set_grid(logic [14:0] w, logic [14:0] h, logic [14:0] d,
                            logic [14:0] ox, logic [14:0] oy, logic [14:0] oz);
        drain_results();
        write_reg(CFG_GRID_WIDTH, w);
        write_reg(CFG_GRID_HEIGHT, h);
        write_reg(CFG_GRID_DEPTH, d);
        write_reg(CFG_ORIGIN_X, ox);
        write_reg(CFG_ORIGIN_Y, oy);
        write_reg(CFG_ORIGIN_Z, oz);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset grid is empty, boundary voxels, an enclosed voxel and an opened neighbor
    task automatic test_surface_rules();
        query_vox(0, 0, 0);
        write_vox(0, 0, 0, 8'hFF);
        query_vox(0, 0, 0);
        write_vox(31, 31, 31, 8'h01);
        query_vox(31, 31, 31);
        // fully enclosed voxel is hidden
        write_vox(10, 10, 10, 8'hA5);
        write_vox(9, 10, 10, 8'h5A);
        write_vox(11, 10, 10, 8'h80);
        write_vox(10, 9, 10, 8'h7F);
        write_vox(10, 11, 10, 8'h02);
        write_vox(10, 10, 9, 8'h40);
        write_vox(10, 10, 11, 8'h15);
        query_vox(10, 10, 10);
        // one empty neighbor exposes it
        write_vox(10, 10, 11, 8'h00);
        query_vox(10, 10, 10);
        query_vox(10, 10, 11);
        write_vox(10, 10, 11, 8'h2A);
        query_vox(10, 10, 10);
    endtask

    // zero extent, saturating extent, single-slice extent and a shrunken boundary
    task automatic test_extent_limits();
        set_grid(15'd0, 15'd32, 15'd32, 15'd0, 15'd0, 15'd0);
        write_vox(5, 5, 5, 8'h33);
        query_vox(0, 0, 0);
        // 63 in the low bits saturates to the full grid
        set_grid(15'h7FFF, 15'd1, 15'd2, 15'd0, 15'd0, 15'd0);
        query_vox(31, 0, 1);
        write_vox(31, 0, 1, 8'h77);
        query_vox(31, 0, 1);
        query_vox(0, 1, 0);
        // enclosed voxel sits on the new x boundary, the one beyond is out of range
        set_grid(15'd11, 15'd32, 15'd32, 15'd0, 15'd0, 15'd0);
        query_vox(10, 10, 10);
        query_vox(11, 10, 10);
        // dropped write left the grid untouched
        query_vox(5, 5, 5);
    endtask

    task automatic test_origin_extremes();
        set_grid(15'd32, 15'd32, 15'd32, 15'h3FFF, 15'h4000, 15'h7FFF);
        query_vox(31, 31, 31);
        query_vox(0, 0, 0);
        set_grid(15'd32, 15'd32, 15'd32, 15'h4000, 15'h3FFF, 15'h0001);
        query_vox(31, 0, 31);
    endtask

    function automatic logic [14:0] random_extent();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70) return 15'($urandom_range(3, 9));
        if (pick < 85) return 15'd32;
        // saturating value with junk above the register width
        return {9'($urandom()), 6'($urandom_range(33, 63))};
    endfunction

    // writes a voxel and its six neighbors, some left empty, then probes around it
    task automatic build_and_probe();
        int w;
        int h;
        int d;
        int cx;
        int cy;
        int cz;
        int nx;
        int ny;
        int nz;
        w  = clamp_extent(ext_w);
        h  = clamp_extent(ext_h);
        d  = clamp_extent(ext_d);
        cx = $urandom_range(1, w - 2);
        cy = $urandom_range(1, h - 2);
        cz = $urandom_range(1, d - 2);
        write_vox(5'(cx), 5'(cy), 5'(cz),
                  ($urandom_range(99) < 10) ? 8'd0 : 8'($urandom_range(1, 255)));
        for (int k = 0; k < 6; k++) begin
            nx = cx;
            ny = cy;
            nz = cz;
            case (k)
                0: nx = cx - 1;
                1: nx = cx + 1;
                2: ny = cy - 1;
                3: ny = cy + 1;
                4: nz = cz - 1;
                default: nz = cz + 1;
            endcase
            write_vox(5'(nx), 5'(ny), 5'(nz),
                      ($urandom_range(99) < 20) ? 8'd0 : 8'($urandom_range(1, 255)));
        end
        query_vox(5'(cx), 5'(cy), 5'(cz));
        repeat ($urandom_range(1, 3)) begin
            query_vox(5'(cx + $urandom_range(0, 2) - 1), 5'(cy + $urandom_range(0, 2) - 1),
                      5'(cz + $urandom_range(0, 2) - 1));
        end
    endtask

    // unstructured items, half of them free to land outside the extent
    task automatic random_noise();
        int w;
        int h;
        int d;
        w = clamp_extent(ext_w);
        h = clamp_extent(ext_h);
        d = clamp_extent(ext_d);
        repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(1))
                send_item(1'($urandom()), 5'($urandom()), 5'($urandom()), 5'($urandom()),
                          8'($urandom()));
            else
                send_item(1'($urandom()), 5'($urandom_range(0, w - 1)),
                          5'($urandom_range(0, h - 1)), 5'($urandom_range(0, d - 1)),
                          8'($urandom()));
        end
    endtask

    task automatic test_random_traffic(int send_pct, int recv_pct, int count);
        int first;
        drain_results();
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        set_grid(random_extent(), random_extent(), random_extent(),
                 15'($urandom()), 15'($urandom()), 15'($urandom()));
        first = items_sent;
        while (items_sent - first < count) begin
            if ($urandom_range(99) < 75) build_and_probe();
            else random_noise();
        end
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_surface_rules();
        test_extent_limits();
        test_origin_extremes();
        test_random_traffic(17, 69, 110);
        test_random_traffic(17, 69, 110);
        test_random_traffic(69, 17, 110);
        test_random_traffic(69, 17, 110);
        test_random_traffic(0, 0, 110);
        test_random_traffic(0, 0, 110);
        drain_results();

        $display("covered %0d items: %0d writes, %0d queries, %0d out of range, %0d cfg writes",
                 items_sent, n_writes, n_queries, n_range_err, n_cfg_writes);
        $display("queries on filled voxels: %0d visible, %0d enclosed; %0d mismatches",
                 n_visible, n_enclosed, mismatches);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
